// ----- rtl/dwt_pkg.sv -----
// Shared widths and fixed-point constants for the detent wheel tracker.
package dwt_pkg;

  localparam int unsigned AngleBits = 16;
  localparam int unsigned Detents   = 48;

  localparam int unsigned TargetW = AngleBits + 1;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned HidW    = 10;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  // Snap arithmetic: position times detent count plus half a turn.
  localparam int unsigned SnapW = TargetW + IndexW;

  // Divide-by-three reciprocals, exact for operands below 2**RecipShiftT
  // and 2**RecipShiftH respectively.
  localparam int unsigned RecipShiftT = 19;
  localparam logic [17:0] RecipT      = 18'd174763;
  localparam int unsigned RecipShiftH = 17;
  localparam logic [15:0] RecipH      = 16'd43691;

  localparam logic [IndexW-1:0]  MaxIndex = IndexW'(Detents);
  localparam logic [TargetW-1:0] FullTurn = TargetW'(1) << AngleBits;

  typedef logic [AngleBits-1:0] angle_t;
  typedef logic [TargetW-1:0]   pos_t;
  typedef logic [IndexW-1:0]    index_t;
  typedef logic [HidW-1:0]      hid_t;

endpackage

// ----- rtl/detent_wheel_tracker.sv -----
// Top level of the detent wheel tracker: four-stage stream pipeline.
// Beats pass the input, tracking, snapping and output registers in order.
// Throughput: one beat per cycle while m_axis_tready is high; each stage holds
// one beat, and the ready chain lets empty stages fill while the output waits.
// Reset (asynchronous, active low) empties the pipeline and clears the
// tracker state, so the next beat is treated as the first sample.
module detent_wheel_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0 up: measured_angle[15:0].
  input  logic [dwt_pkg::InDataW-1:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0 up: target_angle[16:0], snap_index[22:17],
  // scaled_level[32:23], zero fill [39:33].
  output logic [dwt_pkg::OutDataW-1:0] m_axis_tdata,
  // Fields from bit 0 up: target_changed[0].
  output logic        m_axis_tuser
);
  import dwt_pkg::*;

  // Per-stage valid bits and the backward ready chain.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  // Stage 1: input register.
  angle_t a1_q;

  // Stage 2: position tracking, with the tracker state updated as a beat
  // moves from stage 1 into stage 2.
  logic   started_q;
  angle_t prev_q;
  pos_t   track_q;
  pos_t   pos2_q, pos2_d;
  logic   first2_q;

  // Stage 3: detent snapping and the change test.
  index_t cur_q;
  index_t idx3_q, idx3_d;
  logic   chg3_q;

  // Stage 4: output register.
  pos_t   tgt4_q;
  index_t idx4_q;
  hid_t   hid4_q;
  logic   chg4_q;

  pos_t   tgt_w;
  hid_t   hid_w;

  logic signed [AngleBits:0]   diff;
  logic signed [AngleBits+1:0] dwrap;
  logic signed [AngleBits+2:0] psum;
  logic [SnapW-1:0]            snap;
  logic [IndexW:0]             idx_raw;

  // Shortest-way difference, then a saturating add onto the tracked position.
  // A difference of exactly half a turn is left as it is.
  always_comb begin
    diff  = $signed({1'b0, a1_q}) - $signed({1'b0, prev_q});
    dwrap = (AngleBits+2)'(diff);
    if (dwrap > $signed((AngleBits+2)'(FullTurn >> 1))) begin
      dwrap = dwrap - $signed((AngleBits+2)'(FullTurn));
    end else if (dwrap < -$signed((AngleBits+2)'(FullTurn >> 1))) begin
      dwrap = dwrap + $signed((AngleBits+2)'(FullTurn));
    end
    psum = $signed({2'b00, track_q}) + (AngleBits+3)'(dwrap);
    priority if (!started_q) begin
      pos2_d = {1'b0, a1_q};
    end else if (psum < 0) begin
      pos2_d = '0;
    end else if (psum > $signed((AngleBits+3)'(FullTurn))) begin
      pos2_d = FullTurn;
    end else begin
      pos2_d = psum[TargetW-1:0];
    end
  end

  // Nearest detent with ties rounding up: (pos * 48 + half turn) >> 16.
  // The multiply by 48 is two shifted adds.
  always_comb begin
    snap = SnapW'({pos2_q, 5'd0}) + SnapW'({pos2_q, 4'd0}) + SnapW'(FullTurn >> 1);
    idx_raw = snap[SnapW-1:AngleBits];
    if (idx_raw > (IndexW+1)'(MaxIndex)) begin
      idx3_d = MaxIndex;
    end else begin
      idx3_d = idx_raw[IndexW-1:0];
    end
  end

  dwt_quant u_quant (
    .idx_i    (idx3_q),
    .target_o (tgt_w),
    .hid_o    (hid_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      started_q <= 1'b0;
      prev_q    <= '0;
      track_q   <= '0;
      cur_q     <= '0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
        if (v1_q) begin
          started_q <= 1'b1;
          prev_q    <= a1_q;
          track_q   <= pos2_d;
        end
      end
      if (rdy3) begin
        v3_q <= v2_q;
        if (v2_q) begin
          cur_q <= idx3_d;
        end
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  // Payload registers load only when a beat moves into them.
  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      a1_q <= s_axis_tdata[AngleBits-1:0];
    end
    if (rdy2 && v1_q) begin
      pos2_q   <= pos2_d;
      first2_q <= !started_q;
    end
    if (rdy3 && v2_q) begin
      idx3_q <= idx3_d;
      chg3_q <= first2_q || (idx3_d != cur_q);
    end
    if (rdy4 && v3_q) begin
      tgt4_q <= tgt_w;
      idx4_q <= idx3_q;
      hid4_q <= hid_w;
      chg4_q <= chg3_q;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tuser  = chg4_q;
  assign m_axis_tdata  = {(OutDataW-TargetW-IndexW-HidW)'(0), hid4_q, idx4_q, tgt4_q};

endmodule

// ----- rtl/dwt_quant.sv -----
// Maps a detent index to its target angle and its 0..1023 scaled value.
module dwt_quant (
  input  dwt_pkg::index_t idx_i,
  output dwt_pkg::pos_t   target_o,
  output dwt_pkg::hid_t   hid_o
);
  import dwt_pkg::*;

  // target = (idx * 65536 + 24) / 48 = (idx * 4096 + 1) / 3.
  logic [17:0] t_num;
  logic [35:0] t_prod;
  // hid = (idx * 1023) / 48 = ((idx * 1023) >> 4) / 3.
  logic [15:0] h_mul;
  logic [11:0] h_num;
  logic [27:0] h_prod;

  always_comb begin
    t_num  = {idx_i, 12'd0} + 18'd1;
    t_prod = 36'(t_num) * 36'(RecipT);
    target_o = TargetW'(t_prod >> RecipShiftT);

    h_mul  = {idx_i, 10'd0} - 16'(idx_i);
    h_num  = h_mul[15:4];
    h_prod = 28'(h_num) * 28'(RecipH);
    hid_o  = HidW'(h_prod >> RecipShiftH);
  end

endmodule
